### hdl/gpr_pkg.sv
// Package: constants, decode types and mask helpers for the GPIO register block.
package gpr_pkg;

  localparam int NUM_PORTS     = 2;
  localparam int PINS_PER_PORT = 32;
  localparam int MAX_PORTS     = 2;
  localparam int WORD_W        = 32;
  localparam int IDX_W         = 5;
  localparam int PADC_WORDS    = 10;
  localparam int FSEL_WORDS    = 4;
  localparam int PADC_IDX_W    = $clog2(PADC_WORDS);
  localparam int FSEL_IDX_W    = $clog2(FSEL_WORDS);

  localparam logic [WORD_W-1:0] PORT_MASK =
    WORD_W'((64'd1 << PINS_PER_PORT) - 64'd1);

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic ST_OK        = 1'b0;
  localparam logic ST_BAD_INDEX = 1'b1;

  localparam logic [IDX_W-1:0] IDX_DIR0      = 5'd0;
  localparam logic [IDX_W-1:0] IDX_DATA0     = 5'd2;
  localparam logic [IDX_W-1:0] IDX_PADC_LO0  = 5'd4;
  localparam logic [IDX_W-1:0] IDX_PADC_LO1  = 5'd5;
  localparam logic [IDX_W-1:0] IDX_FSEL0     = 5'd6;
  localparam logic [IDX_W-1:0] IDX_FSEL3     = 5'd9;
  localparam logic [IDX_W-1:0] IDX_PADC_HI0  = 5'd10;
  localparam logic [IDX_W-1:0] IDX_PADC_HI7  = 5'd17;
  localparam logic [IDX_W-1:0] IDX_DSET0     = 5'd18;
  localparam logic [IDX_W-1:0] IDX_DCLR0     = 5'd20;
  localparam logic [IDX_W-1:0] IDX_ESET0     = 5'd22;
  localparam logic [IDX_W-1:0] IDX_ECLR0     = 5'd24;
  localparam logic [IDX_W-1:0] IDX_ECLR1     = 5'd25;

  typedef enum logic [3:0] {
    K_DIR, K_DATA, K_PADC, K_FSEL, K_DSET, K_DCLR, K_ESET, K_ECLR, K_BAD
  } reg_kind_t;

  typedef struct packed {
    reg_kind_t               kind;
    logic                    port;
    logic [PADC_IDX_W-1:0]   padc_sel;
    logic [FSEL_IDX_W-1:0]   fsel_sel;
  } dec_t;

  // Writable bits of function-select word k: two bits per present pin.
  function automatic logic [WORD_W-1:0] sel_mask(input logic [FSEL_IDX_W-1:0] k);
    logic [WORD_W-1:0] m;
    logic [5:0]        pin;
    m = '0;
    for (int j = 0; j < 16; j++) begin
      pin = {k, 4'(j)};
      if (int'(pin[4:0]) < PINS_PER_PORT) m[2*j +: 2] = 2'b11;
    end
    return m;
  endfunction

endpackage

### hdl/gpr_decode.sv
// Register-map decode of a word index into access kind, port and store slot.
module gpr_decode (
  input  logic [gpr_pkg::IDX_W-1:0] word_index,
  output gpr_pkg::dec_t             dec
);
  import gpr_pkg::*;

  logic [IDX_W-1:0] padc_off;
  logic [IDX_W-1:0] fsel_off;
  logic             present;

  always_comb begin
    dec          = '0;
    dec.kind     = K_BAD;
    dec.port     = word_index[0];
    padc_off     = (word_index <= IDX_PADC_LO1) ? word_index - IDX_PADC_LO0
                                                : word_index - 5'd8;
    fsel_off     = word_index - IDX_FSEL0;
    dec.padc_sel = padc_off[PADC_IDX_W-1:0];
    dec.fsel_sel = fsel_off[FSEL_IDX_W-1:0];
    case (word_index) inside
      [IDX_DIR0:IDX_DIR0+5'd1]:         dec.kind = K_DIR;
      [IDX_DATA0:IDX_DATA0+5'd1]:       dec.kind = K_DATA;
      [IDX_PADC_LO0:IDX_PADC_LO1]:      dec.kind = K_PADC;
      [IDX_FSEL0:IDX_FSEL3]:            dec.kind = K_FSEL;
      [IDX_PADC_HI0:IDX_PADC_HI7]:      dec.kind = K_PADC;
      [IDX_DSET0:IDX_DSET0+5'd1]:       dec.kind = K_DSET;
      [IDX_DCLR0:IDX_DCLR0+5'd1]:       dec.kind = K_DCLR;
      [IDX_ESET0:IDX_ESET0+5'd1]:       dec.kind = K_ESET;
      [IDX_ECLR0:IDX_ECLR1]:            dec.kind = K_ECLR;
      default:                          dec.kind = K_BAD;
    endcase
    if (dec.kind == K_FSEL) present = int'(dec.fsel_sel >> 1) < NUM_PORTS;
    else                    present = int'(dec.port) < NUM_PORTS;
    if (!present) dec.kind = K_BAD;
  end

endmodule

### hdl/gpr_regfile.sv
// Register stores, read mux and set/clear update for one access.
module gpr_regfile (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic                        wr,
  input  gpr_pkg::dec_t               dec,
  input  logic [gpr_pkg::WORD_W-1:0]  wdata,
  input  logic [2*gpr_pkg::WORD_W-1:0] pads,
  output logic [gpr_pkg::WORD_W-1:0]  rdata,
  output logic                        status,
  output logic [2*gpr_pkg::WORD_W-1:0] drive_nxt,
  output logic [2*gpr_pkg::WORD_W-1:0] enable_nxt
);
  import gpr_pkg::*;

  logic [WORD_W-1:0] dir_r   [MAX_PORTS];
  logic [WORD_W-1:0] latch_r [MAX_PORTS];
  logic [WORD_W-1:0] fsel_r  [FSEL_WORDS];
  logic [WORD_W-1:0] padc_r  [PADC_WORDS];
  logic [WORD_W-1:0] dir_nxt   [MAX_PORTS];
  logic [WORD_W-1:0] latch_nxt [MAX_PORTS];
  logic [WORD_W-1:0] wm;
  logic [WORD_W-1:0] lv;
  logic              we;

  always_comb begin
    wm        = wdata & PORT_MASK;
    we        = fire && wr;
    lv        = dec.port ? pads[2*WORD_W-1:WORD_W] : pads[WORD_W-1:0];
    dir_nxt   = dir_r;
    latch_nxt = latch_r;
    rdata     = '0;
    status    = ST_OK;
    case (dec.kind)
      K_DIR: begin
        if (wr) dir_nxt[dec.port] = wm;
        else rdata = dir_r[dec.port];
      end
      K_DATA: begin
        if (wr) latch_nxt[dec.port] = wm;
        else rdata = ((lv & ~dir_r[dec.port]) | (latch_r[dec.port] & dir_r[dec.port]))
                     & PORT_MASK;
      end
      K_PADC: if (!wr) rdata = padc_r[dec.padc_sel];
      K_FSEL: if (!wr) rdata = fsel_r[dec.fsel_sel];
      K_DSET: if (wr) latch_nxt[dec.port] = latch_r[dec.port] | wm;
      K_DCLR: if (wr) latch_nxt[dec.port] = latch_r[dec.port] & ~wm;
      K_ESET: if (wr) dir_nxt[dec.port] = dir_r[dec.port] | wm;
      K_ECLR: if (wr) dir_nxt[dec.port] = dir_r[dec.port] & ~wm;
      default: status = ST_BAD_INDEX;
    endcase
    if (!fire) begin
      dir_nxt   = dir_r;
      latch_nxt = latch_r;
    end
    drive_nxt  = {latch_nxt[1], latch_nxt[0]};
    enable_nxt = {dir_nxt[1], dir_nxt[0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < MAX_PORTS; p++) begin
        dir_r[p]   <= '0;
        latch_r[p] <= '0;
      end
      for (int i = 0; i < FSEL_WORDS; i++) fsel_r[i] <= '0;
      for (int i = 0; i < PADC_WORDS; i++) padc_r[i] <= '0;
    end else begin
      dir_r   <= dir_nxt;
      latch_r <= latch_nxt;
      if (we && dec.kind == K_FSEL) fsel_r[dec.fsel_sel] <= wdata & sel_mask(dec.fsel_sel);
      if (we && dec.kind == K_PADC) padc_r[dec.padc_sel] <= wm;
    end
  end

endmodule

### hdl/gpio_port_register_block.sv
// Top level: input register, register-map decode, register file, result register.
//
//  channel   ports                                         transfer
//  input     start, busy, in_opcode .. in_pad_levels       start && !busy at clk edge
//  result    out_valid, out_read_data .. out_pin_enable    out_valid for one cycle
//
// One transfer per cycle; busy is always low. The input register feeds decode and the
// register file; the result register and the stores load at the next edge, so a result
// is on the out_ ports once it has passed the input register and the result register,
// and is taken at the edge that ends its out_valid cycle.
// Synchronous reset clears all stores, so every pin is an input driving zero; the
// out_pin_ ports are not reset. The receiver cannot stall; results are never held.
module gpio_port_register_block (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_opcode,
  input  logic [gpr_pkg::IDX_W-1:0]           in_word_index,
  input  logic [gpr_pkg::WORD_W-1:0]          in_write_data,
  input  logic [2*gpr_pkg::WORD_W-1:0]        in_pad_levels,
  output logic                                out_valid,
  output logic [gpr_pkg::WORD_W-1:0]          out_read_data,
  output logic                                out_status,
  output logic [2*gpr_pkg::WORD_W-1:0]        out_pin_drive,
  output logic [2*gpr_pkg::WORD_W-1:0]        out_pin_enable
);
  import gpr_pkg::*;

  logic                  vld_r;
  logic                  op_r;
  logic [IDX_W-1:0]      idx_r;
  logic [WORD_W-1:0]     wd_r;
  logic [2*WORD_W-1:0]   pads_r;
  dec_t                  dec;
  logic [WORD_W-1:0]     rdata;
  logic                  status;
  logic [2*WORD_W-1:0]   drive_nxt;
  logic [2*WORD_W-1:0]   enable_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else        vld_r <= start && !busy;
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r   <= in_opcode;
      idx_r  <= in_word_index;
      wd_r   <= in_write_data;
      pads_r <= in_pad_levels;
    end
  end

  gpr_decode u_decode (
    .word_index (idx_r),
    .dec        (dec)
  );

  gpr_regfile u_regfile (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (vld_r),
    .wr         (op_r == OP_WRITE),
    .dec        (dec),
    .wdata      (wd_r),
    .pads       (pads_r),
    .rdata      (rdata),
    .status     (status),
    .drive_nxt  (drive_nxt),
    .enable_nxt (enable_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= vld_r;
  end

  always_ff @(posedge clk) begin
    if (vld_r) begin
      out_read_data  <= rdata;
      out_status     <= status;
      out_pin_drive  <= drive_nxt;
      out_pin_enable <= enable_nxt;
    end
  end

endmodule

### tb/gpio_port_register_block_tb.sv
// Testbench for gpio_port_register_block: directed table and random accesses vs. a predictor.
`timescale 1ns / 100ps

module gpio_port_register_block_tb;
  import gpr_pkg::*;

  localparam logic [IDX_W-1:0] IDX_DIR1      = IDX_DIR0 + 1'b1;
  localparam logic [IDX_W-1:0] IDX_DATA1     = IDX_DATA0 + 1'b1;
  localparam logic [IDX_W-1:0] IDX_DSET1     = IDX_DSET0 + 1'b1;
  localparam logic [IDX_W-1:0] IDX_DCLR1     = IDX_DCLR0 + 1'b1;
  localparam logic [IDX_W-1:0] IDX_ESET1     = IDX_ESET0 + 1'b1;
  localparam logic [IDX_W-1:0] IDX_FIRST_BAD = IDX_ECLR1 + 1'b1;
  localparam logic [IDX_W-1:0] IDX_LAST_BAD  = '1;

  localparam int PADC_LO_WORDS = IDX_PADC_LO1 - IDX_PADC_LO0 + 1;
  localparam int DIRECTED_ROWS = 25;
  localparam int CYCLE_LIMIT   = 60000;
  localparam int DRAIN_CYCLES  = 8;

  typedef struct packed {
    logic                    op;
    logic [IDX_W-1:0]        idx;
    logic [WORD_W-1:0]       wdata;
    logic [2*WORD_W-1:0]     pads;
  } access_t;

  typedef struct packed {
    logic [WORD_W-1:0]       read_data;
    logic                    status;
    logic [2*WORD_W-1:0]     pin_drive;
    logic [2*WORD_W-1:0]     pin_enable;
  } gpio_result_t;

  typedef struct packed {
    access_t                 acc;
    logic                    typed;
    logic [WORD_W-1:0]       rd;
    logic                    st;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic in_opcode;
  logic [IDX_W-1:0] in_word_index;
  logic [WORD_W-1:0] in_write_data;
  logic [2*WORD_W-1:0] in_pad_levels;
  logic out_valid;
  logic [WORD_W-1:0] out_read_data;
  logic out_status;
  logic [2*WORD_W-1:0] out_pin_drive;
  logic [2*WORD_W-1:0] out_pin_enable;

  logic [WORD_W-1:0] dir_store [NUM_PORTS];
  logic [WORD_W-1:0] latch_store [NUM_PORTS];
  logic [WORD_W-1:0] fsel_store [FSEL_WORDS];
  logic [WORD_W-1:0] padc_store [PADC_WORDS];

  gpio_result_t pending_results [$];
  int error_count = 0;
  int cycle_count = 0;
  int sender_idle_pct = 0;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{OP_READ,  IDX_DIR0,      32'h0,         64'h0},                  1'b1, 32'h0, ST_OK},
    '{'{OP_READ,  IDX_DATA0,     32'h0,         '1},                     1'b1, '1,    ST_OK},
    '{'{OP_READ,  IDX_DATA1,     32'h0,         64'hAAAA_AAAA_5555_5555}, 1'b1, 32'hAAAA_AAAA, ST_OK},
    '{'{OP_WRITE, IDX_DIR0,      '1,            64'h0},                  1'b1, 32'h0, ST_OK},
    '{'{OP_WRITE, IDX_DATA0,     32'h0,         64'h0},                  1'b1, 32'h0, ST_OK},
    '{'{OP_READ,  IDX_DATA0,     32'h0,         '1},                     1'b1, 32'h0, ST_OK},
    '{'{OP_WRITE, IDX_DIR1,      32'h0000_FFFF, 64'h0},                  1'b0, 32'h0, ST_OK},
    '{'{OP_WRITE, IDX_DATA1,     '1,            64'h0},                  1'b0, 32'h0, ST_OK},
    '{'{OP_READ,  IDX_DATA1,     32'h0,         64'h0},                  1'b0, 32'h0, ST_OK},
    '{'{OP_WRITE, IDX_DSET0,     32'h0F0F_0F0F, 64'h0},                  1'b0, 32'h0, ST_OK},
    '{'{OP_WRITE, IDX_DCLR1,     32'hFFFF_0000, 64'h0},                  1'b0, 32'h0, ST_OK},
    '{'{OP_WRITE, IDX_ESET1,     32'hFFFF_0000, 64'h0},                  1'b0, 32'h0, ST_OK},
    '{'{OP_WRITE, IDX_ECLR0,     32'h0000_FFFF, 64'h0},                  1'b0, 32'h0, ST_OK},
    '{'{OP_READ,  IDX_DSET1,     '1,            '1},                     1'b1, 32'h0, ST_OK},
    '{'{OP_READ,  IDX_DATA0,     32'h0,         64'h0123_4567_89AB_CDEF}, 1'b0, 32'h0, ST_OK},
    '{'{OP_WRITE, IDX_PADC_LO0,  '1,            64'h0},                  1'b0, 32'h0, ST_OK},
    '{'{OP_READ,  IDX_PADC_LO1,  32'h0,         64'h0},                  1'b0, 32'h0, ST_OK},
    '{'{OP_WRITE, IDX_PADC_HI7,  32'h1234_5678, 64'h0},                  1'b0, 32'h0, ST_OK},
    '{'{OP_READ,  IDX_PADC_HI7,  32'h0,         64'h0},                  1'b0, 32'h0, ST_OK},
    '{'{OP_WRITE, IDX_FSEL0,     '1,            64'h0},                  1'b0, 32'h0, ST_OK},
    '{'{OP_READ,  IDX_FSEL3,     32'h0,         64'h0},                  1'b0, 32'h0, ST_OK},
    '{'{OP_READ,  IDX_FSEL0,     32'h0,         64'h0},                  1'b0, 32'h0, ST_OK},
    '{'{OP_WRITE, IDX_FIRST_BAD, '1,            '1},                     1'b1, 32'h0, ST_BAD_INDEX},
    '{'{OP_READ,  IDX_LAST_BAD,  32'h0,         '1},                     1'b1, 32'h0, ST_BAD_INDEX},
    '{'{OP_READ,  IDX_ECLR1,     32'h0,         64'h0},                  1'b1, 32'h0, ST_OK}
  };

  gpio_port_register_block u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_word_index  (in_word_index),
    .in_write_data  (in_write_data),
    .in_pad_levels  (in_pad_levels),
    .out_valid      (out_valid),
    .out_read_data  (out_read_data),
    .out_status     (out_status),
    .out_pin_drive  (out_pin_drive),
    .out_pin_enable (out_pin_enable)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Two writable bits per pin that exists in its port.
  function automatic logic [WORD_W-1:0] fsel_field_mask(input int word);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int j = 0; j < WORD_W / 2; j++) begin
      if (((word * (WORD_W / 2) + j) % WORD_W) < PINS_PER_PORT) m[2*j +: 2] = 2'b11;
    end
    return m;
  endfunction

  function automatic gpio_result_t apply_access(input access_t a);
    gpio_result_t r;
    logic port;
    logic present;
    logic [WORD_W-1:0] m;
    logic [WORD_W-1:0] lv;
    int k;
    r = '0;
    port = a.idx[0];
    m = a.wdata & PORT_MASK;
    if (a.idx >= IDX_FSEL0 && a.idx <= IDX_FSEL3)
      present = (int'(a.idx - IDX_FSEL0) >> 1) < NUM_PORTS;
    else
      present = int'(port) < NUM_PORTS;
    if (a.idx > IDX_ECLR1 || !present) begin
      r.status = ST_BAD_INDEX;
    end else if (a.idx < IDX_DATA0) begin
      if (a.op == OP_WRITE) dir_store[port] = m;
      else r.read_data = dir_store[port];
    end else if (a.idx < IDX_PADC_LO0) begin
      if (a.op == OP_WRITE) begin
        latch_store[port] = m;
      end else begin
        lv = a.pads[port*WORD_W +: WORD_W];
        r.read_data = ((lv & ~dir_store[port]) | (latch_store[port] & dir_store[port]))
                      & PORT_MASK;
      end
    end else if (a.idx >= IDX_FSEL0 && a.idx <= IDX_FSEL3) begin
      k = int'(a.idx - IDX_FSEL0);
      if (a.op == OP_WRITE) fsel_store[k] = a.wdata & fsel_field_mask(k);
      else r.read_data = fsel_store[k];
    end else if (a.idx <= IDX_PADC_HI7) begin
      k = (a.idx <= IDX_PADC_LO1) ? int'(a.idx - IDX_PADC_LO0)
                                  : int'(a.idx - IDX_PADC_HI0) + PADC_LO_WORDS;
      if (a.op == OP_WRITE) padc_store[k] = m;
      else r.read_data = padc_store[k];
    end else if (a.op == OP_WRITE) begin
      if (a.idx < IDX_DCLR0) latch_store[port] = latch_store[port] | m;
      else if (a.idx < IDX_ESET0) latch_store[port] = latch_store[port] & ~m;
      else if (a.idx < IDX_ECLR0) dir_store[port] = dir_store[port] | m;
      else dir_store[port] = dir_store[port] & ~m;
    end
    r.pin_drive  = {latch_store[1], latch_store[0]};
    r.pin_enable = {dir_store[1], dir_store[0]};
    return r;
  endfunction

  function automatic access_t random_access();
    access_t a;
    int pick;
    a.op = ($urandom_range(0, 99) < 55) ? OP_WRITE : OP_READ;
    if ($urandom_range(0, 9) == 0)
      a.idx = IDX_W'($urandom_range(IDX_FIRST_BAD, IDX_LAST_BAD));
    else
      a.idx = IDX_W'($urandom_range(IDX_DIR0, IDX_ECLR1));
    pick = $urandom_range(0, 7);
    case (pick)
      0: a.wdata = '0;
      1: a.wdata = '1;
      2: a.wdata = 32'h1 << $urandom_range(0, WORD_W - 1);
      default: a.wdata = $urandom;
    endcase
    pick = $urandom_range(0, 9);
    case (pick)
      0: a.pads = '0;
      1: a.pads = '1;
      default: a.pads = {$urandom, $urandom};
    endcase
    return a;
  endfunction

  task automatic issue(input access_t a, input logic typed, input logic [WORD_W-1:0] t_rd,
                       input logic t_st);
    gpio_result_t r;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_opcode     <= a.op;
    in_word_index <= a.idx;
    in_write_data <= a.wdata;
    in_pad_levels <= a.pads;
    do @(posedge clk); while (busy);
    r = apply_access(a);
    if (typed) begin
      r.read_data = t_rd;
      r.status    = t_st;
    end
    pending_results.push_back(r);
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  always @(posedge clk) begin
    gpio_result_t e;
    if (rst_n && out_valid !== 1'b0) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result expected none actual read_data %h status %b", $time,
                 out_read_data, out_status);
      end else begin
        e = pending_results.pop_front();
        if (out_valid !== 1'b1) begin
          error_count++;
          $display("%0t: out_valid expected 1 actual %b", $time, out_valid);
        end
        if (out_read_data !== e.read_data) begin
          error_count++;
          $display("%0t: read_data expected %h actual %h", $time, e.read_data, out_read_data);
        end
        if (out_status !== e.status) begin
          error_count++;
          $display("%0t: status expected %b actual %b", $time, e.status, out_status);
        end
        if (out_pin_drive !== e.pin_drive) begin
          error_count++;
          $display("%0t: pin_drive expected %h actual %h", $time, e.pin_drive, out_pin_drive);
        end
        if (out_pin_enable !== e.pin_enable) begin
          error_count++;
          $display("%0t: pin_enable expected %h actual %h", $time, e.pin_enable,
                   out_pin_enable);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL gpio_port_register_block");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_opcode     = OP_READ;
    in_word_index = IDX_DIR0;
    in_write_data = '0;
    in_pad_levels = '0;
    for (int p = 0; p < NUM_PORTS; p++) begin
      dir_store[p]   = '0;
      latch_store[p] = '0;
    end
    for (int w = 0; w < FSEL_WORDS; w++) fsel_store[w] = '0;
    for (int w = 0; w < PADC_WORDS; w++) padc_store[w] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idle_pct = 15;
    foreach (directed_rows[i])
      issue(directed_rows[i].acc, directed_rows[i].typed, directed_rows[i].rd,
            directed_rows[i].st);
    wait_results_drained();

    repeat (220) issue(random_access(), 1'b0, '0, ST_OK);
    wait_results_drained();
    sender_idle_pct = 56;
    repeat (220) issue(random_access(), 1'b0, '0, ST_OK);
    wait_results_drained();
    sender_idle_pct = 0;
    repeat (210) issue(random_access(), 1'b0, '0, ST_OK);
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) $display("PASS gpio_port_register_block");
    else $display("FAIL gpio_port_register_block");
    $finish;
  end

endmodule

### sim.f
hdl/gpr_pkg.sv
hdl/gpr_decode.sv
hdl/gpr_regfile.sv
hdl/gpio_port_register_block.sv
tb/gpio_port_register_block_tb.sv
